// ===== design/acsd_pkg.sv =====
// Shared constants, register indexes and types of the averaged class score decider.
package acsd_pkg;

    localparam int DEF_CLASS_COUNT    = 2;
    localparam int DEF_HISTORY_LENGTH = 8;

    localparam int MAX_CLASS = 4;
    localparam int SCORE_W   = 16;
    localparam int SUM_W     = 22;
    localparam int CLASS_W   = 2;
    localparam int SUPP_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int IN_DATA_W = MAX_CLASS * SCORE_W;
    localparam int OUT_DATA_W = 8;

    localparam logic [SCORE_W-1:0] RST_THRESHOLD = 16'd26214;
    localparam logic [SUPP_W-1:0]  RST_DURATION  = 8'd25;
    localparam logic [CLASS_W-1:0] RST_NO_DET    = 2'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD = 2'd0,
        REG_DURATION  = 2'd1,
        REG_NO_DET    = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [SCORE_W-1:0] threshold;
        logic [SUPP_W-1:0]  duration;
        logic [CLASS_W-1:0] no_det_class;
    } t_cfg;

endpackage

// ===== design/acsd_window.sv =====
// Score history memory and per-class running window sums.
module acsd_window #(
    parameter int CLASS_COUNT    = acsd_pkg::DEF_CLASS_COUNT,
    parameter int HISTORY_LENGTH = acsd_pkg::DEF_HISTORY_LENGTH
) (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    input  logic                                             i_accept,
    input  logic [acsd_pkg::MAX_CLASS-1:0][acsd_pkg::SCORE_W-1:0] i_scores,
    input  logic                                             i_adv,
    output logic                                             o_ready,
    output logic                                             o_vld,
    output logic [CLASS_COUNT-1:0][acsd_pkg::SUM_W-1:0]      o_sums
);
    import acsd_pkg::*;

    localparam int SLOT_W = (HISTORY_LENGTH > 1) ? $clog2(HISTORY_LENGTH) : 1;
    localparam int ROW_W  = CLASS_COUNT * SCORE_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(HISTORY_LENGTH - 1);
    localparam logic [SUM_W-1:0]  SUM_BOUND = SUM_W'(HISTORY_LENGTH * 65535);

    logic [ROW_W-1:0]                    r_mem [HISTORY_LENGTH];
    logic [HISTORY_LENGTH-1:0]           r_row_vld;
    logic [SLOT_W-1:0]                   r_slot;
    logic [SLOT_W-1:0]                   n_slot;
    logic [ROW_W-1:0]                    r_rd;
    logic [ROW_W-1:0]                    r_byp;
    logic                                r_use_byp;
    logic                                r_old_vld;
    logic [CLASS_COUNT-1:0][SUM_W-1:0]   r_sum;
    logic [CLASS_COUNT-1:0][SUM_W-1:0]   n_sum;
    logic [ROW_W-1:0]                    new_row;
    logic [ROW_W-1:0]                    old_row;
    logic                                r_s1_vld;

    assign n_slot  = (r_slot == LAST_SLOT) ? '0 : r_slot + SLOT_W'(1);
    assign new_row = i_scores[CLASS_COUNT-1:0];
    assign old_row = r_old_vld ? (r_use_byp ? r_byp : r_rd) : '0;

    always_comb begin
        for (int c = 0; c < CLASS_COUNT; c++) begin
            n_sum[c] = r_sum[c] - SUM_W'(old_row[c*SCORE_W +: SCORE_W])
                       + SUM_W'(i_scores[c]);
        end
    end

    // memory write and registered prefetch of the next slot
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_mem[r_slot] <= new_row;
            r_rd          <= r_mem[n_slot];
            r_byp         <= new_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_slot    <= '0;
            r_old_vld <= 1'b0;
            r_use_byp <= 1'b0;
            r_sum     <= '0;
        end else if (i_accept) begin
            r_row_vld[r_slot] <= 1'b1;
            r_slot            <= n_slot;
            r_use_byp         <= (n_slot == r_slot);
            r_old_vld         <= (n_slot == r_slot) || r_row_vld[n_slot];
            r_sum             <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (o_ready) begin
            r_s1_vld <= i_accept;
        end
    end

    assign o_ready = !r_s1_vld || i_adv;
    assign o_vld   = r_s1_vld;
    assign o_sums  = r_sum;

`ifndef SYNTHESIS
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= LAST_SLOT)
        else $error("history slot out of range");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_s1_vld)
        else $error("sum stage valid after reset");

    for (genvar g = 0; g < CLASS_COUNT; g++) begin : g_bound
        a_sum_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_sum[g] <= SUM_BOUND)
            else $error("window sum exceeds full-scale window");
    end
`endif

endmodule

// ===== design/acsd_decide.sv =====
// Argmax over window sums, threshold and suppression decision, result register.
module acsd_decide #(
    parameter int CLASS_COUNT    = acsd_pkg::DEF_CLASS_COUNT,
    parameter int HISTORY_LENGTH = acsd_pkg::DEF_HISTORY_LENGTH
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_vld,
    input  logic [CLASS_COUNT-1:0][acsd_pkg::SUM_W-1:0] i_sums,
    input  acsd_pkg::t_cfg                              i_cfg,
    input  logic                                        i_tready,
    output logic                                        o_adv,
    output logic                                        o_tvalid,
    output logic [acsd_pkg::CLASS_W-1:0]                o_class,
    output logic                                        o_detected
);
    import acsd_pkg::*;

    localparam int CMP_W = SUM_W + 1;

    logic [CLASS_W-1:0] best;
    logic [SUM_W-1:0]   best_sum;
    logic [CMP_W-1:0]   limit;
    logic [SUPP_W-1:0]  supp_dec;
    logic               quiet;
    logic [SUPP_W-1:0]  r_supp;
    logic               r_out_vld;
    logic [CLASS_W-1:0] r_class;
    logic               r_det;

    always_comb begin
        best     = '0;
        best_sum = i_sums[0];
        for (int c = 1; c < CLASS_COUNT; c++) begin
            if (i_sums[c] > best_sum) begin
                best     = CLASS_W'(c);
                best_sum = i_sums[c];
            end
        end
    end

    assign limit    = CMP_W'(i_cfg.threshold) * CMP_W'(HISTORY_LENGTH);
    assign supp_dec = (r_supp != '0) ? r_supp - SUPP_W'(1) : r_supp;
    assign quiet    = (best == i_cfg.no_det_class) || (CMP_W'(best_sum) < limit)
                      || (supp_dec != '0);
    assign o_adv    = !r_out_vld || i_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_supp    <= '0;
            r_out_vld <= 1'b0;
        end else if (o_adv) begin
            r_out_vld <= i_vld;
            if (i_vld) begin
                r_supp <= quiet ? supp_dec : i_cfg.duration;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && i_vld) begin
            r_class <= quiet ? i_cfg.no_det_class : best;
            r_det   <= !quiet;
        end
    end

    assign o_tvalid   = r_out_vld;
    assign o_class    = r_class;
    assign o_detected = r_det;

`ifndef SYNTHESIS
    a_suppress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_adv && i_vld && r_supp > SUPP_W'(1)) |=> (r_out_vld && !r_det))
        else $error("detection reported while suppression pending");

    a_det_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_det) |->
        ((CLASS_W+1)'(r_class) < (CLASS_W+1)'(CLASS_COUNT)))
        else $error("detected class outside class range");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_vld)
        else $error("result valid after reset");
`endif

endmodule

// ===== design/averaged_class_score_decider.sv =====
// Top level: averaged class score decider with config registers and stream ports.
// An input beat is summed into the window register, then decided into the result register.
// Throughput: one score vector per unstalled cycle, set by the window running-sum update.
// Backpressure on the result side stalls both stages; one beat is taken while a result waits.
// Reset is synchronous, active low: config returns to defaults, history, sums, slot and
// suppression clear at once, so the block takes beats in the first cycle after reset.
module averaged_class_score_decider #(
    parameter int CLASS_COUNT    = acsd_pkg::DEF_CLASS_COUNT,
    parameter int HISTORY_LENGTH = acsd_pkg::DEF_HISTORY_LENGTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // score_class_0, score_class_1, score_class_2, score_class_3
    input  logic [acsd_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // decided_class, zero fill
    output logic [acsd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // detected
    output logic                             m_axis_tuser,
    input  logic                             i_cfg_we,
    input  logic [acsd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [acsd_pkg::CFG_DAT_W-1:0]   i_cfg_data
);
    import acsd_pkg::*;

    t_cfg                              r_cfg;
    logic                              accept;
    logic                              adv;
    logic                              s1_vld;
    logic [CLASS_COUNT-1:0][SUM_W-1:0] sums;
    logic [CLASS_W-1:0]                dec_class;
    logic [MAX_CLASS-1:0][SCORE_W-1:0] scores;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold    <= RST_THRESHOLD;
            r_cfg.duration     <= RST_DURATION;
            r_cfg.no_det_class <= RST_NO_DET;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_THRESHOLD: r_cfg.threshold    <= i_cfg_data;
                REG_DURATION:  r_cfg.duration     <= i_cfg_data[SUPP_W-1:0];
                REG_NO_DET:    r_cfg.no_det_class <= i_cfg_data[CLASS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign scores = s_axis_tdata;
    assign accept = s_axis_tvalid && s_axis_tready;

    acsd_window #(
        .CLASS_COUNT    (CLASS_COUNT),
        .HISTORY_LENGTH (HISTORY_LENGTH)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_scores (scores),
        .i_adv    (adv),
        .o_ready  (s_axis_tready),
        .o_vld    (s1_vld),
        .o_sums   (sums)
    );

    acsd_decide #(
        .CLASS_COUNT    (CLASS_COUNT),
        .HISTORY_LENGTH (HISTORY_LENGTH)
    ) u_decide (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (s1_vld),
        .i_sums     (sums),
        .i_cfg      (r_cfg),
        .i_tready   (m_axis_tready),
        .o_adv      (adv),
        .o_tvalid   (m_axis_tvalid),
        .o_class    (dec_class),
        .o_detected (m_axis_tuser)
    );

    assign m_axis_tdata = {{(OUT_DATA_W - CLASS_W){1'b0}}, dec_class};

endmodule

// ===== test/tb_averaged_class_score_decider.sv =====
// Testbench for the averaged class score decider: streamed score vectors, predicted decisions.
`timescale 1ns / 100ps

module tb_averaged_class_score_decider;
    import acsd_pkg::*;

    localparam int NCLS  = DEF_CLASS_COUNT;
    localparam int HLEN  = DEF_HISTORY_LENGTH;
    localparam int DRAIN = 6;
    localparam int PHASES = 9;
    localparam int PHASE_ITEMS = 210;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [CLASS_W-1:0] cls;
        logic               det;
    } t_decision;

    class decision_board;
        logic [SCORE_W-1:0] threshold;
        logic [SUPP_W-1:0]  duration;
        logic [CLASS_W-1:0] no_det;
        logic [SCORE_W-1:0] history [NCLS*HLEN];
        logic [SUM_W-1:0]   sums [NCLS];
        int                 slot;
        logic [SUPP_W-1:0]  hold_left;
        t_decision          due[$];
        int                 mismatches;

        function new();
            threshold = RST_THRESHOLD;
            duration  = RST_DURATION;
            no_det    = RST_NO_DET;
            foreach (history[i]) history[i] = '0;
            foreach (sums[c]) sums[c] = '0;
            slot       = 0;
            hold_left  = '0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
            case (idx)
                REG_THRESHOLD: threshold = val[SCORE_W-1:0];
                REG_DURATION:  duration  = val[SUPP_W-1:0];
                REG_NO_DET:    no_det    = val[CLASS_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_scores(logic [IN_DATA_W-1:0] beat);
            logic [SCORE_W-1:0] s;
            logic [SUM_W-1:0]   best_sum;
            logic [63:0]        floor_sum;
            int                 best;
            bit                 quiet;
            t_decision          d;
            for (int c = 0; c < NCLS; c++) begin
                s = beat[c*SCORE_W +: SCORE_W];
                sums[c] = sums[c] - history[c*HLEN + slot] + s;
                history[c*HLEN + slot] = s;
            end
            slot = (slot + 1) % HLEN;
            best = 0;
            best_sum = sums[0];
            for (int c = 1; c < NCLS; c++) begin
                if (sums[c] > best_sum) begin
                    best = c;
                    best_sum = sums[c];
                end
            end
            if (hold_left != 0) hold_left--;
            floor_sum = 64'(threshold) * 64'(HLEN);
            quiet = (best == no_det) || (64'(best_sum) < floor_sum) || (hold_left != 0);
            if (quiet) begin
                d.cls = no_det;
                d.det = 1'b0;
            end else begin
                hold_left = duration;
                d.cls = best[CLASS_W-1:0];
                d.det = 1'b1;
            end
            due.push_back(d);
        endfunction

        function void check_decision(logic [CLASS_W-1:0] cls, logic det);
            t_decision want;
            if (due.size() == 0) begin
                $error("unexpected result beat: decided_class %0d detected %0b", cls, det);
                mismatches++;
                return;
            end
            want = due.pop_front();
            if (cls !== want.cls) begin
                $error("decided_class expected %0d actual %0d", want.cls, cls);
                mismatches++;
            end
            if (det !== want.det) begin
                $error("detected expected %0b actual %0b", want.det, det);
                mismatches++;
            end
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [CFG_DAT_W-1:0]   i_cfg_data = '0;

    decision_board sb;
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;

    averaged_class_score_decider dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_scores(s_axis_tdata);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_decision(m_axis_tdata[CLASS_W-1:0], m_axis_tuser);
    end

    function automatic logic [IN_DATA_W-1:0] pack_scores(logic [SCORE_W-1:0] s0,
            logic [SCORE_W-1:0] s1, logic [SCORE_W-1:0] s2, logic [SCORE_W-1:0] s3);
        return {s3, s2, s1, s0};
    endfunction

    function automatic logic [SCORE_W-1:0] noise_score();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 16'hFFFF;
            2: return 16'd32768;
            default: return SCORE_W'($urandom);
        endcase
    endfunction

    function automatic logic [SCORE_W-1:0] strong_score();
        int lo;
        int hi;
        if ($urandom_range(0, 7) == 0) return 16'hFFFF;
        lo = (sb.threshold > 3000) ? sb.threshold - 3000 : 0;
        hi = (sb.threshold + 9000 > 65535) ? 65535 : sb.threshold + 9000;
        return SCORE_W'($urandom_range(lo, hi));
    endfunction

    task automatic send_item(logic [IN_DATA_W-1:0] beat);
        int gap;
        if ($urandom_range(0, 49) == 0) tx_idle_on = !tx_idle_on;
        gap = tx_idle_on ? $urandom_range(0, 17) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= beat;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.due.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        sb.set_reg(idx, val);
        @(posedge i_clk);
    endtask

    task automatic program_regs(logic [SCORE_W-1:0] thr, logic [SUPP_W-1:0] dur,
            logic [CLASS_W-1:0] nd);
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_DURATION, {8'($urandom), dur});
        write_reg(REG_NO_DET, {14'($urandom), nd});
        write_reg(REG_SPARE, CFG_DAT_W'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_random(int count);
        int sent;
        int g;
        int len;
        logic [SCORE_W-1:0] sc [4];
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 3) != 0) begin
                g = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : $urandom_range(0, NCLS-1);
                len = $urandom_range(4, 2*HLEN);
                for (int k = 0; k < len && sent < count; k++) begin
                    for (int c = 0; c < 4; c++) begin
                        sc[c] = (c == g) ? strong_score() : SCORE_W'($urandom_range(0, 20000));
                        if ($urandom_range(0, 15) == 0) sc[c] = noise_score();
                    end
                    send_item(pack_scores(sc[0], sc[1], sc[2], sc[3]));
                    sent++;
                end
            end else begin
                len = $urandom_range(1, 10);
                for (int k = 0; k < len && sent < count; k++) begin
                    send_item(pack_scores(noise_score(), noise_score(), noise_score(),
                                          noise_score()));
                    sent++;
                end
            end
        end
    endtask

    initial begin
        int stall;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 49) == 0) rx_idle_on = !rx_idle_on;
            stall = rx_idle_on ? $urandom_range(0, 17) : 0;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
        end
    end

    initial begin
        #1_000_000;
        $display("tb_averaged_class_score_decider NOT OK");
        $finish;
    end

    initial begin
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(pack_scores(16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_item(pack_scores(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        repeat (8) send_item(pack_scores(16'd0, 16'd32768, 16'hFFFF, 16'd0));
        repeat (8) send_item(pack_scores(16'd32768, 16'd0, 16'd0, 16'hFFFF));
        repeat (4) send_item(pack_scores(16'd30000, 16'd30000, 16'd0, 16'd0));

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: ;
                1: program_regs(16'd0, 8'd0, 2'd0);
                2: program_regs(16'd32768, 8'd255, 2'd3);
                3: program_regs(16'hFFFF, 8'd1, 2'd2);
                4: program_regs(16'd16000, 8'd3, 2'd1);
                5: program_regs(16'd20000, 8'd2, 2'd0);
                default: program_regs(SCORE_W'($urandom_range(0, 32768)),
                                      SUPP_W'($urandom_range(0, 255)),
                                      CLASS_W'($urandom_range(0, 3)));
            endcase
            run_random(PHASE_ITEMS);
            settle();
        end

        if (sb.mismatches == 0 && sb.due.size() == 0) begin
            $display("tb_averaged_class_score_decider OK");
        end else begin
            $display("tb_averaged_class_score_decider NOT OK");
        end
        $finish;
    end

endmodule
